@@ sv/snell_refraction_vector_macros.svh @@
// Assertion macros for the refraction pipeline.
// Used by snell_refraction_vector; needs i_clk and i_rst_n in scope.
`ifndef SNELL_REFRACTION_VECTOR_MACROS_SVH
`define SNELL_REFRACTION_VECTOR_MACROS_SVH

// same-cycle implication
`define SRV_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SRV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/srv_pkg.sv @@
// Shared constants and pipeline payload types for the refraction block.
// No dependencies.
package srv_pkg;

    localparam int FW         = 16;
    localparam int SQ_IN_W    = 60;
    localparam int SQ_OUT_W   = 30;
    localparam int SQ_STAGES  = SQ_OUT_W;
    localparam int DIV_STAGES = 16;
    localparam int NUM_W      = 44;
    localparam int LAT        = 87;

    typedef struct packed {
        logic [2:0][FW-1:0] mag;
        logic [2:0]         neg;
        logic [2:0][FW-1:0] nrm;
        logic [FW-1:0]      eta;
        logic               zero;
    } t_norm_side;

    typedef struct packed {
        logic [2:0][NUM_W-1:0]    num;
        logic [2:0][DIV_STAGES-1:0] quo;
        logic [SQ_OUT_W-1:0]      den;
        logic [2:0]               neg;
        logic [2:0][FW-1:0]       nrm;
        logic [FW-1:0]            eta;
        logic                     zero;
    } t_div_lane;

    typedef struct packed {
        logic [2:0][31:0]   a;
        logic [2:0][FW-1:0] nrm;
        logic [FW-1:0]      eta;
        logic               ok;
    } t_refr_side;

endpackage

@@ sv/srv_in_if.sv @@
// Input channel: incident direction, surface normal and index ratio.
// Depends on srv_pkg.
interface srv_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [srv_pkg::FW-1:0]      inc_x;
    logic signed [srv_pkg::FW-1:0]      inc_y;
    logic signed [srv_pkg::FW-1:0]      inc_z;
    logic signed [srv_pkg::FW-1:0]      norm_x;
    logic signed [srv_pkg::FW-1:0]      norm_y;
    logic signed [srv_pkg::FW-1:0]      norm_z;
    logic        [srv_pkg::FW-1:0]      eta;

    modport source (output valid, inc_x, inc_y, inc_z, norm_x, norm_y, norm_z, eta,
                    input ready);
    modport sink   (input valid, inc_x, inc_y, inc_z, norm_x, norm_y, norm_z, eta,
                    output ready);
endinterface

@@ sv/srv_out_if.sv @@
// Output channel: refracted direction and refraction flag.
// Depends on srv_pkg.
interface srv_out_if;
    logic                          valid;
    logic                          ready;
    logic signed [srv_pkg::FW-1:0] refr_x;
    logic signed [srv_pkg::FW-1:0] refr_y;
    logic signed [srv_pkg::FW-1:0] refr_z;
    logic                          valid_res;

    modport source (output valid, refr_x, refr_y, refr_z, valid_res, input ready);
    modport sink   (input valid, refr_x, refr_y, refr_z, valid_res, output ready);
endinterface

@@ sv/srv_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on srv_pkg.
module srv_isqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [srv_pkg::SQ_IN_W-1:0]   i_x,
    output logic [srv_pkg::SQ_OUT_W-1:0]  o_root
);

    logic [srv_pkg::SQ_IN_W-1:0]    r_x    [srv_pkg::SQ_STAGES];
    logic [srv_pkg::SQ_OUT_W+1:0]   r_rem  [srv_pkg::SQ_STAGES];
    logic [srv_pkg::SQ_OUT_W-1:0]   r_root [srv_pkg::SQ_STAGES];

    for (genvar k = 0; k < srv_pkg::SQ_STAGES; k++) begin : g_stage
        logic [srv_pkg::SQ_IN_W-1:0]  x_in;
        logic [srv_pkg::SQ_OUT_W+1:0] rem_in;
        logic [srv_pkg::SQ_OUT_W-1:0] root_in;
        logic [srv_pkg::SQ_OUT_W+1:0] n_rem_sh;
        logic [srv_pkg::SQ_OUT_W+1:0] n_trial;

        if (k == 0) begin : g_first
            assign x_in    = i_x;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign x_in    = r_x[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        assign n_rem_sh = {rem_in[srv_pkg::SQ_OUT_W-1:0], x_in[srv_pkg::SQ_IN_W-1 -: 2]};
        assign n_trial  = {root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k] <= {x_in[srv_pkg::SQ_IN_W-3:0], 2'b00};
                if (n_rem_sh >= n_trial) begin
                    r_rem[k]  <= n_rem_sh - n_trial;
                    r_root[k] <= {root_in[srv_pkg::SQ_OUT_W-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= n_rem_sh;
                    r_root[k] <= {root_in[srv_pkg::SQ_OUT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[srv_pkg::SQ_STAGES-1];

endmodule

@@ sv/snell_refraction_vector.sv @@
// Throughput: one item per cycle; the whole pipeline holds while the result waits.
// Built from two 30-stage square root pipelines and a 16-stage divider.
// Reset: synchronous, active low; clears all stage valid bits, payload is not reset.
// Depends on srv_pkg, srv_in_if, srv_out_if, srv_isqrt and the macros header.
`include "snell_refraction_vector_macros.svh"

module snell_refraction_vector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srv_in_if.sink      i_in,
    srv_out_if.source   o_res
);

    logic                         adv;
    logic [srv_pkg::LAT-1:0]      r_vld;

    logic signed [srv_pkg::FW-1:0] n_inc [3];
    logic signed [srv_pkg::FW-1:0] n_nrm [3];

    // stage 1/2
    logic [30:0]                  r_sq1 [3];
    srv_pkg::t_norm_side          r_s1;
    srv_pkg::t_norm_side          r_s2;
    logic [srv_pkg::SQ_IN_W-1:0]  r_x2;

    // sqrt of length
    logic [srv_pkg::SQ_OUT_W-1:0] len;
    srv_pkg::t_norm_side          r_sa [srv_pkg::SQ_STAGES];

    // divider
    srv_pkg::t_div_lane           r_div [srv_pkg::DIV_STAGES+1];
    srv_pkg::t_div_lane           n_div [srv_pkg::DIV_STAGES+1];

    // dot product and discriminant
    logic signed [15:0]           r_u5 [3];
    logic signed [15:0]           r_n5 [3];
    logic [15:0]                  r_eta5;
    logic                         r_zero5;

    logic signed [31:0]           r_p6 [3];
    logic signed [15:0]           r_u6 [3];
    logic signed [15:0]           r_n6 [3];
    logic [15:0]                  r_eta6;
    logic                         r_zero6;

    logic signed [15:0]           r_dt7;
    logic signed [15:0]           n_dt7;
    logic signed [15:0]           r_u7 [3];
    logic signed [15:0]           r_n7 [3];
    logic [15:0]                  r_eta7;
    logic                         r_zero7;

    logic [30:0]                  r_dt2_8;
    logic [31:0]                  r_eta2_8;
    logic signed [31:0]           r_ndt8 [3];
    logic signed [15:0]           r_u8 [3];
    logic signed [15:0]           r_n8 [3];
    logic [15:0]                  r_eta8;
    logic                         r_zero8;

    logic signed [64:0]           r_prod9;
    logic signed [31:0]           r_a9 [3];
    logic signed [15:0]           r_n9 [3];
    logic [15:0]                  r_eta9;
    logic                         r_zero9;

    logic [38:0]                  r_disc10;
    srv_pkg::t_refr_side          r_s10;
    logic [38:0]                  n_disc10;
    logic                         n_ok10;

    logic [srv_pkg::SQ_OUT_W-1:0] sq;
    srv_pkg::t_refr_side          r_sb [srv_pkg::SQ_STAGES];

    logic signed [48:0]           r_ea11 [3];
    logic signed [36:0]           r_nsq11 [3];
    logic                         r_ok11;

    logic signed [15:0]           r_refr [3];
    logic                         r_valid_res;
    logic signed [15:0]           n_refr [3];

    logic                         res_stall;
    logic                         res_tir;
    logic                         res_clear;

    assign adv         = !r_vld[srv_pkg::LAT-1] || o_res.ready;
    assign i_in.ready  = adv;

    assign n_inc[0] = i_in.inc_x;
    assign n_inc[1] = i_in.inc_y;
    assign n_inc[2] = i_in.inc_z;
    assign n_nrm[0] = i_in.norm_x;
    assign n_nrm[1] = i_in.norm_y;
    assign n_nrm[2] = i_in.norm_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[srv_pkg::LAT-2:0], i_in.valid};
        end
    end

    // squares, magnitudes, length argument
    always_ff @(posedge i_clk) begin
        logic signed [31:0] sq_v;
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                sq_v         = n_inc[j] * n_inc[j];
                r_sq1[j]     <= sq_v[30:0];
                r_s1.mag[j]  <= n_inc[j][15] ? 16'(-n_inc[j]) : 16'(n_inc[j]);
                r_s1.neg[j]  <= n_inc[j][15];
                r_s1.nrm[j]  <= n_nrm[j];
            end
            r_s1.eta  <= i_in.eta;
            r_s1.zero <= (n_inc[0] == '0) && (n_inc[1] == '0) && (n_inc[2] == '0);

            r_x2      <= {32'(r_sq1[0]) + 32'(r_sq1[1]) + 32'(r_sq1[2]), 28'd0};
            r_s2      <= r_s1;
        end
    end

    srv_isqrt u_len (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_x    (r_x2),
        .o_root (len)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sa[0] <= r_s2;
            for (int k = 1; k < srv_pkg::SQ_STAGES; k++) begin
                r_sa[k] <= r_sa[k-1];
            end
        end
    end

    // divider setup and restoring division stages
    always_comb begin
        logic [srv_pkg::NUM_W+1:0] dsh;
        logic [srv_pkg::NUM_W+1:0] nx;
        n_div[0] = r_div[0];
        for (int j = 0; j < 3; j++) begin
            n_div[0].num[j] = srv_pkg::NUM_W'({r_sa[srv_pkg::SQ_STAGES-1].mag[j], 28'd0})
                            + srv_pkg::NUM_W'(len[srv_pkg::SQ_OUT_W-1:1]);
            n_div[0].quo[j] = '0;
        end
        n_div[0].den  = len;
        n_div[0].neg  = r_sa[srv_pkg::SQ_STAGES-1].neg;
        n_div[0].nrm  = r_sa[srv_pkg::SQ_STAGES-1].nrm;
        n_div[0].eta  = r_sa[srv_pkg::SQ_STAGES-1].eta;
        n_div[0].zero = r_sa[srv_pkg::SQ_STAGES-1].zero;

        for (int k = 1; k <= srv_pkg::DIV_STAGES; k++) begin
            n_div[k] = r_div[k-1];
            dsh = (srv_pkg::NUM_W+2)'(r_div[k-1].den) << (srv_pkg::DIV_STAGES - k);
            for (int j = 0; j < 3; j++) begin
                nx = (srv_pkg::NUM_W+2)'(r_div[k-1].num[j]);
                if (nx >= dsh) begin
                    n_div[k].num[j] = srv_pkg::NUM_W'(nx - dsh);
                    n_div[k].quo[j][srv_pkg::DIV_STAGES-k] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k <= srv_pkg::DIV_STAGES; k++) begin
                r_div[k] <= n_div[k];
            end
        end
    end

    // unit vector, dot product, dt
    always_comb begin
        logic signed [33:0] dsum;
        logic signed [33:0] drnd;
        dsum = 34'(r_p6[0]) + 34'(r_p6[1]) + 34'(r_p6[2]);
        drnd = (dsum + (dsum[33] ? 34'sd8191 : 34'sd8192)) >>> 14;
        if (drnd > 34'sd32767) begin
            n_dt7 = 16'sh7fff;
        end else if (drnd < -34'sd32768) begin
            n_dt7 = 16'sh8000;
        end else begin
            n_dt7 = 16'(drnd);
        end
    end

    always_ff @(posedge i_clk) begin
        logic [15:0]        qc;
        logic signed [31:0] dt2_v;
        logic signed [31:0] om;
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                qc = (r_div[srv_pkg::DIV_STAGES].quo[j] > 16'd16384) ? 16'd16384
                     : r_div[srv_pkg::DIV_STAGES].quo[j];
                r_u5[j] <= r_div[srv_pkg::DIV_STAGES].neg[j] ? $signed(-qc) : $signed(qc);
                r_n5[j] <= $signed(r_div[srv_pkg::DIV_STAGES].nrm[j]);

                r_p6[j] <= r_u5[j] * r_n5[j];
                r_u6[j] <= r_u5[j];
                r_n6[j] <= r_n5[j];

                r_u7[j] <= r_u6[j];
                r_n7[j] <= r_n6[j];

                r_ndt8[j] <= r_n7[j] * r_dt7;
                r_u8[j]   <= r_u7[j];
                r_n8[j]   <= r_n7[j];

                r_a9[j] <= (32'(r_u8[j]) <<< 14) - r_ndt8[j];
                r_n9[j] <= r_n8[j];
            end
            r_eta5  <= r_div[srv_pkg::DIV_STAGES].eta;
            r_zero5 <= r_div[srv_pkg::DIV_STAGES].zero;
            r_eta6  <= r_eta5;
            r_zero6 <= r_zero5;
            r_dt7   <= n_dt7;
            r_eta7  <= r_eta6;
            r_zero7 <= r_zero6;

            dt2_v    = r_dt7 * r_dt7;
            r_dt2_8  <= dt2_v[30:0];
            r_eta2_8 <= r_eta7 * r_eta7;
            r_eta8   <= r_eta7;
            r_zero8  <= r_zero7;

            om       = 32'sd268435456 - $signed({1'b0, r_dt2_8});
            r_prod9  <= om * $signed({1'b0, r_eta2_8});
            r_eta9   <= r_eta8;
            r_zero9  <= r_zero8;
        end
    end

    // discriminant
    always_comb begin
        logic signed [64:0] rt;
        logic signed [39:0] term;
        logic signed [40:0] disc;
        rt       = (r_prod9 + (r_prod9[64] ? 65'sd8388607 : 65'sd8388608)) >>> 24;
        term     = rt[39:0];
        disc     = 41'sd268435456 - 41'(term);
        n_ok10   = !r_zero9 && !disc[40] && (disc != '0);
        n_disc10 = disc[38:0];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_disc10 <= n_disc10;
            for (int j = 0; j < 3; j++) begin
                r_s10.a[j]   <= r_a9[j];
                r_s10.nrm[j] <= r_n9[j];
            end
            r_s10.eta <= r_eta9;
            r_s10.ok  <= n_ok10;
        end
    end

    srv_isqrt u_disc (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_x    (srv_pkg::SQ_IN_W'(r_disc10)),
        .o_root (sq)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sb[0] <= r_s10;
            for (int k = 1; k < srv_pkg::SQ_STAGES; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // refracted direction
    always_comb begin
        logic signed [49:0] acc;
        logic signed [49:0] rr;
        for (int j = 0; j < 3; j++) begin
            acc = 50'(r_ea11[j]) - (50'(r_nsq11[j]) <<< 12);
            rr  = (acc + (acc[49] ? 50'sd33554431 : 50'sd33554432)) >>> 26;
            if (!r_ok11) begin
                n_refr[j] = '0;
            end else if (rr > 50'sd32767) begin
                n_refr[j] = 16'sh7fff;
            end else if (rr < -50'sd32768) begin
                n_refr[j] = 16'sh8000;
            end else begin
                n_refr[j] = 16'(rr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                r_ea11[j]  <= $signed({1'b0, r_sb[srv_pkg::SQ_STAGES-1].eta})
                              * $signed(r_sb[srv_pkg::SQ_STAGES-1].a[j]);
                r_nsq11[j] <= $signed(r_sb[srv_pkg::SQ_STAGES-1].nrm[j])
                              * $signed({1'b0, sq[19:0]});
                r_refr[j]  <= n_refr[j];
            end
            r_ok11      <= r_sb[srv_pkg::SQ_STAGES-1].ok;
            r_valid_res <= r_ok11;
        end
    end

    assign o_res.valid     = r_vld[srv_pkg::LAT-1];
    assign o_res.refr_x    = r_refr[0];
    assign o_res.refr_y    = r_refr[1];
    assign o_res.refr_z    = r_refr[2];
    assign o_res.valid_res = r_valid_res;

    assign res_stall = o_res.valid && !o_res.ready;
    assign res_tir   = o_res.valid && !o_res.valid_res;
    assign res_clear = (r_refr[0] == '0) && (r_refr[1] == '0) && (r_refr[2] == '0);

    `SRV_ASSERT_SAME(a_stall_blocks_input, res_stall, !i_in.ready, "input taken while stalled")
    `SRV_ASSERT_SAME(a_no_refr_is_zero, res_tir, res_clear, "nonzero vector without refraction")
    `SRV_ASSERT_NEXT(a_transfer_enters, i_in.valid && i_in.ready, r_vld[0], "transfer lost")

endmodule
